@@ hdl/wrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_pkg
// Widths, codes and shared types of the weighted reservoir sampler.
// ----------------------------------------------------------------------------
package wrs_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int TAG_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CNTIN_W = 16;
    localparam int DRAW_W  = 24;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 24;
    localparam int PROD_W  = 64;
    localparam int MODE_W  = 2;

    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    // merge_mode codes; the two unused codes behave as biased merge
    localparam logic [MODE_W-1:0] MODE_RAW      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNBIASED = 2'd2;

    // register index, taken from paddr above the byte offset
    localparam logic [PADDR_W-3:0] REG_MERGE_MODE = 1'b0;

    // candidate as it arrives on the ports
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [VAL_W-1:0]   wt;
        logic [VAL_W-1:0]   tgt;
        logic [VAL_W-1:0]   iw;
        logic [CNTIN_W-1:0] cnt;
        logic [DRAW_W-1:0]  draw;
        logic               last;
    } t_cand;

    // classified candidate: resampling weight and count increment resolved
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [VAL_W-1:0]   tgt;
        logic [SUM_W-1:0]   w;
        logic [CNTIN_W-1:0] inc;
        logic [DRAW_W-1:0]  draw;
        logic               last;
    } t_item;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] n;
        logic [VAL_W-1:0] phat;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ACC,
        B_DRAW,
        B_CMP,
        B_DIVGO,
        B_DIVWAIT,
        B_OUT
    } t_back_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHK,
        DV_RUN,
        DV_DONE
    } t_div_state;

endpackage

@@ hdl/weighted_reservoir_sampler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_reservoir_sampler_core
// Streaming weighted reservoir with a queue interface and an APB-style
// configuration port.
// ----------------------------------------------------------------------------
// Candidates stream in through push/full and are folded into one reservoir;
// the item flagged last_item produces a single result (chosen sample, its
// target, the contribution weight in Q16.16 and the saturated total count)
// on the empty/pop side, after which the reservoir clears itself. The front
// end takes one candidate per cycle, while full is low, into a two-stage
// weight pipeline (target times incoming weight, then times count) and a
// queue of QUEUE_DEPTH entries; it raises full only when that queue and
// both stages are taken. The back end handles one candidate at a time (pop,
// accumulate the saturating sums, multiply the draw by the new weight sum,
// compare and update the choice), since each decision needs the sum that
// includes the candidate. A last item then starts the divider, which forms
// count times target, checks for overflow and then produces the 32-bit
// quotient one bit per cycle. The result sits in an output register, so the
// back end keeps working while it waits to be popped. merge_mode (register
// 0, byte address 0) selects raw, biased or unbiased merge; write it only
// while no candidate is in flight.
// ----------------------------------------------------------------------------
module weighted_reservoir_sampler_core #(
    parameter int FRACTION_BITS = wrs_pkg::FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH   = wrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // candidate side
    input  logic                          push,
    output logic                          full,
    input  logic [wrs_pkg::TAG_W-1:0]     i_sample_id,
    input  logic [wrs_pkg::VAL_W-1:0]     i_weight,
    input  logic [wrs_pkg::VAL_W-1:0]     i_target,
    input  logic [wrs_pkg::VAL_W-1:0]     i_incoming_weight,
    input  logic [wrs_pkg::CNTIN_W-1:0]   i_count,
    input  logic [wrs_pkg::DRAW_W-1:0]    i_random_draw,
    input  logic                          i_last_item,
    // result side
    output logic                          empty,
    input  logic                          pop,
    output logic [wrs_pkg::TAG_W-1:0]     o_chosen_sample,
    output logic [wrs_pkg::VAL_W-1:0]     o_chosen_target,
    output logic [wrs_pkg::VAL_W-1:0]     o_contribution_weight,
    output logic [wrs_pkg::CNT_W-1:0]     o_total_count,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wrs_pkg::PADDR_W-1:0]   paddr,
    input  logic [wrs_pkg::APB_W-1:0]     pwdata,
    output logic [wrs_pkg::APB_W-1:0]     prdata,
    output logic                          pready
);
    import wrs_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic              cfg_wr;
    logic              reg_hit;

    t_cand     cand;
    t_item     fq_item, qb_item;
    logic      fq_push, fq_full;
    logic      qb_pop, qb_empty;
    t_div_req  div_req;
    t_div_stat div_stat;
    logic [VAL_W-1:0] div_quot;
    logic      out_valid;

    // Configuration: write on the access phase, read back combinationally.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_MERGE_MODE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = reg_hit ? APB_W'(r_mode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RAW;
        end else if (cfg_wr && reg_hit) begin
            r_mode <= pwdata[MODE_W-1:0];
        end
    end

    // Gather the candidate fields for the front end.
    always_comb begin
        cand.tag  = i_sample_id;
        cand.wt   = i_weight;
        cand.tgt  = i_target;
        cand.iw   = i_incoming_weight;
        cand.cnt  = i_count;
        cand.draw = i_random_draw;
        cand.last = i_last_item;
    end

    // Front: accept and classify.
    wrs_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_push   (push),
        .o_full   (full),
        .i_cand   (cand),
        .i_q_full (fq_full),
        .o_q_push (fq_push),
        .o_q_item (fq_item)
    );

    // Decouple front and back so each can stall on its own.
    wrs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_item  (fq_item),
        .o_full  (fq_full),
        .i_pop   (qb_pop),
        .o_item  (qb_item),
        .o_empty (qb_empty)
    );

    // Back: fold into the reservoir, hold the result.
    wrs_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_mode                (r_mode),
        .i_q_empty             (qb_empty),
        .o_q_pop               (qb_pop),
        .i_q_item              (qb_item),
        .o_div_req             (div_req),
        .i_div_stat            (div_stat),
        .i_div_quot            (div_quot),
        .i_out_pop             (pop),
        .o_out_valid           (out_valid),
        .o_chosen_sample       (o_chosen_sample),
        .o_chosen_target       (o_chosen_target),
        .o_contribution_weight (o_contribution_weight),
        .o_total_count         (o_total_count)
    );

    // Contribution weight divider, started once per reservoir.
    wrs_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    assign empty = !out_valid;

endmodule

@@ hdl/wrs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_front
// Accepts candidates and works out their resampling weight and count step.
// ----------------------------------------------------------------------------
module wrs_front #(
    parameter int FRACTION_BITS = wrs_pkg::FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [wrs_pkg::MODE_W-1:0]  i_mode,
    input  logic                        i_push,
    output logic                        o_full,
    input  wrs_pkg::t_cand              i_cand,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output wrs_pkg::t_item              o_q_item
);
    import wrs_pkg::*;

    logic              r1_v, n1_v, r2_v, n2_v;
    t_cand             r1_cand, r2_cand;
    logic [PROD_W-1:0] r1_prod, r2_prod;
    logic              r2_psat;
    logic [PROD_W-1:0] prod_sh;
    logic              adv2, mv1, acc;
    logic [PROD_W-1:0] prod_in;

    assign prod_in = i_cand.tgt * i_cand.iw;
    assign prod_sh = r1_prod >> FRACTION_BITS;

    assign adv2   = r2_v && !i_q_full;
    assign mv1    = r1_v && (!r2_v || adv2);
    assign acc    = i_push && (!r1_v || mv1);
    assign o_full = r1_v && !mv1;

    always_comb begin
        n1_v = r1_v;
        if (acc) begin
            n1_v = 1'b1;
        end else if (mv1) begin
            n1_v = 1'b0;
        end
        n2_v = r2_v;
        if (mv1) begin
            n2_v = 1'b1;
        end else if (adv2) begin
            n2_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            r1_v <= n1_v;
            r2_v <= n2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_cand <= i_cand;
            r1_prod <= prod_in;
        end
        if (mv1) begin
            r2_cand <= r1_cand;
            r2_psat <= |prod_sh[PROD_W-1:SUM_W];
            r2_prod <= prod_sh[SUM_W-1:0] * r1_cand.cnt;
        end
    end

    // classify: raw weight and unit step, or product weight and incoming count
    always_comb begin
        o_q_push      = r2_v;
        o_q_item.tag  = r2_cand.tag;
        o_q_item.tgt  = r2_cand.tgt;
        o_q_item.draw = r2_cand.draw;
        o_q_item.last = r2_cand.last;
        if (i_mode == MODE_RAW) begin
            o_q_item.w   = SUM_W'(r2_cand.wt);
            o_q_item.inc = CNTIN_W'(1);
        end else begin
            o_q_item.inc = r2_cand.cnt;
            if (r2_psat || (|r2_prod[PROD_W-1:SUM_W])) begin
                o_q_item.w = SUM_MAX;
            end else begin
                o_q_item.w = r2_prod[SUM_W-1:0];
            end
        end
    end

endmodule

@@ hdl/wrs_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_queue
// Short first-in first-out queue of classified candidates.
// ----------------------------------------------------------------------------
module wrs_queue #(
    parameter int DEPTH = wrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wrs_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output wrs_pkg::t_item o_item,
    output logic           o_empty
);
    import wrs_pkg::*;

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd, n_wr, n_rd;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              wr_en, rd_en;

    assign o_full  = (r_fill == FILL_W'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (wr_en) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        n_fill = r_fill;
        if (wr_en && !rd_en) begin
            n_fill = r_fill + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ hdl/wrs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_div
// Contribution weight: weight sum over count times target, one bit a cycle.
// ----------------------------------------------------------------------------
module wrs_div #(
    parameter int FRACTION_BITS = wrs_pkg::FRACTION_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wrs_pkg::t_div_req         i_req,
    output wrs_pkg::t_div_stat        o_stat,
    output logic [wrs_pkg::VAL_W-1:0] o_quot
);
    import wrs_pkg::*;

    localparam int D_W    = CNT_W + VAL_W;
    localparam int R_W    = D_W + 1;
    localparam int N_W    = SUM_W + FRACTION_BITS;
    localparam int CMP_W  = D_W + VAL_W - FRACTION_BITS;
    localparam int STEP_W = $clog2(VAL_W);

    t_div_state        r_state, n_state;
    logic [D_W-1:0]    r_d;
    logic [SUM_W-1:0]  r_sum;
    logic              r_n_zero, r_p_zero;
    logic [R_W-1:0]    r_r;
    logic [VAL_W-1:0]  r_l;
    logic [STEP_W-1:0] r_step;
    logic [N_W-1:0]    dividend;
    logic [CMP_W-1:0]  d_lim;
    logic              over;
    logic [R_W-1:0]    r_sh;
    logic              fits;

    assign dividend = N_W'(r_sum) << FRACTION_BITS;
    // quotient overflows 32 bits exactly when sum >= d * 2^(32-FRACTION_BITS)
    assign d_lim    = CMP_W'(r_d) << (VAL_W - FRACTION_BITS);
    assign over     = CMP_W'(r_sum) >= d_lim;
    assign r_sh     = {r_r[R_W-2:0], r_l[VAL_W-1]};
    assign fits     = r_sh >= R_W'(r_d);
    assign o_quot   = r_l;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DV_IDLE: begin
                if (i_req.start) begin
                    n_state = DV_CHK;
                end
            end
            DV_CHK: begin
                n_state = (r_p_zero || r_n_zero || over) ? DV_DONE : DV_RUN;
            end
            DV_RUN: begin
                if (r_step == STEP_W'(VAL_W - 1)) begin
                    n_state = DV_DONE;
                end
            end
            DV_DONE: begin
                n_state = DV_IDLE;
            end
            default: begin
                n_state = DV_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stat.busy = (r_state != DV_IDLE);
        o_stat.done = (r_state == DV_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            DV_IDLE: begin
                if (i_req.start) begin
                    r_d      <= i_req.n * i_req.phat;
                    r_sum    <= i_req.sum;
                    r_n_zero <= (i_req.n == '0);
                    r_p_zero <= (i_req.phat == '0);
                end
            end
            DV_CHK: begin
                priority if (r_p_zero) begin
                    r_l <= '0;
                end else if (r_n_zero) begin
                    r_l <= (r_sum != '0) ? VAL_MAX : '0;
                end else if (over) begin
                    r_l <= VAL_MAX;
                end else begin
                    // high part is below the divisor once overflow is ruled out
                    r_r    <= R_W'(dividend >> VAL_W);
                    r_l    <= dividend[VAL_W-1:0];
                    r_step <= '0;
                end
            end
            DV_RUN: begin
                r_r    <= fits ? (r_sh - R_W'(r_d)) : r_sh;
                r_l    <= {r_l[VAL_W-2:0], fits};
                r_step <= r_step + 1'b1;
            end
            DV_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

@@ hdl/wrs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_back
// Reservoir update, draw decision and result register.
// ----------------------------------------------------------------------------
module wrs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [wrs_pkg::MODE_W-1:0]  i_mode,
    input  logic                        i_q_empty,
    output logic                        o_q_pop,
    input  wrs_pkg::t_item              i_q_item,
    output wrs_pkg::t_div_req           o_div_req,
    input  wrs_pkg::t_div_stat          i_div_stat,
    input  logic [wrs_pkg::VAL_W-1:0]   i_div_quot,
    input  logic                        i_out_pop,
    output logic                        o_out_valid,
    output logic [wrs_pkg::TAG_W-1:0]   o_chosen_sample,
    output logic [wrs_pkg::VAL_W-1:0]   o_chosen_target,
    output logic [wrs_pkg::VAL_W-1:0]   o_contribution_weight,
    output logic [wrs_pkg::CNT_W-1:0]   o_total_count
);
    import wrs_pkg::*;

    localparam int PHI_W = SUM_W + 1;
    localparam int PLO_W = 2 * DRAW_W;
    localparam int ACC_W = SUM_W + 2;

    t_back_state      r_state, n_state;
    t_item            r_cur;
    logic [SUM_W-1:0] r_wsum, n_wsum;
    logic [CNT_W-1:0] r_cnt, n_cnt, r_pos, n_pos;
    logic [TAG_W-1:0] r_held_tag;
    logic [VAL_W-1:0] r_held_tgt;
    logic [PHI_W-1:0] r_phi;
    logic [PLO_W-1:0] r_plo;
    logic             r_out_valid;
    logic [TAG_W-1:0] r_out_tag;
    logic [VAL_W-1:0] r_out_tgt, r_out_cw;
    logic [CNT_W-1:0] r_out_cnt;

    logic [SUM_W:0]   sum_add;
    logic [CNT_W:0]   cnt_add, pos_add;
    logic [SUM_W:0]   s_inc;
    logic [ACC_W-1:0] draw_acc, w_lim;
    logic             take;
    logic             out_free;

    assign sum_add = {1'b0, r_wsum} + (SUM_W + 1)'(r_cur.w);
    assign cnt_add = {1'b0, r_cnt} + (CNT_W + 1)'(r_cur.inc);
    assign pos_add = {1'b0, r_pos} + (CNT_W + 1)'(r_cur.inc);
    assign n_wsum  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    assign n_cnt   = cnt_add[CNT_W] ? CNT_MAX : cnt_add[CNT_W-1:0];
    assign n_pos   = pos_add[CNT_W] ? CNT_MAX : pos_add[CNT_W-1:0];

    // draw * (sum + 1) split at the draw's fraction point
    assign s_inc    = {1'b0, r_wsum} + 1'b1;
    assign draw_acc = ACC_W'(r_phi) + ACC_W'(r_plo[PLO_W-1:DRAW_W]);
    assign w_lim    = ACC_W'(r_cur.w) + 1'b1;
    assign take     = draw_acc < w_lim;

    assign out_free = !r_out_valid || i_out_pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = B_ACC;
                end
            end
            B_ACC: begin
                n_state = B_DRAW;
            end
            B_DRAW: begin
                n_state = B_CMP;
            end
            B_CMP: begin
                n_state = r_cur.last ? B_DIVGO : B_IDLE;
            end
            B_DIVGO: begin
                if (!i_div_stat.busy) begin
                    n_state = B_DIVWAIT;
                end
            end
            B_DIVWAIT: begin
                if (i_div_stat.done) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        o_q_pop         = (r_state == B_IDLE);
        o_div_req.start = (r_state == B_DIVGO) && !i_div_stat.busy;
        o_div_req.sum   = r_wsum;
        o_div_req.n     = (i_mode == MODE_UNBIASED) ? r_pos : r_cnt;
        o_div_req.phat  = r_held_tgt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_wsum      <= '0;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_held_tag  <= '0;
            r_held_tgt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_ACC) begin
                r_wsum <= n_wsum;
                r_cnt  <= n_cnt;
                if (r_cur.tgt != '0) begin
                    r_pos <= n_pos;
                end
            end
            if ((r_state == B_CMP) && take) begin
                r_held_tag <= r_cur.tag;
                r_held_tgt <= r_cur.tgt;
            end
            if ((r_state == B_OUT) && out_free) begin
                r_wsum      <= '0;
                r_cnt       <= '0;
                r_pos       <= '0;
                r_held_tag  <= '0;
                r_held_tgt  <= '0;
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == B_IDLE) && !i_q_empty) begin
            r_cur <= i_q_item;
        end
        if (r_state == B_DRAW) begin
            r_phi <= r_cur.draw * s_inc[SUM_W:DRAW_W];
            r_plo <= r_cur.draw * s_inc[DRAW_W-1:0];
        end
        if ((r_state == B_OUT) && out_free) begin
            r_out_tag <= r_held_tag;
            r_out_tgt <= r_held_tgt;
            r_out_cw  <= i_div_quot;
            r_out_cnt <= r_cnt;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_chosen_sample       = r_out_tag;
    assign o_chosen_target       = r_out_tgt;
    assign o_contribution_weight = r_out_cw;
    assign o_total_count         = r_out_cnt;

endmodule

@@ hdl/wrs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_checker
// Port-level checks of the weighted reservoir sampler, bound to the core.
// ----------------------------------------------------------------------------
module wrs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [wrs_pkg::TAG_W-1:0]     o_chosen_sample,
    input logic [wrs_pkg::VAL_W-1:0]     o_chosen_target,
    input logic [wrs_pkg::VAL_W-1:0]     o_contribution_weight
);
    import wrs_pkg::*;

    // Reset leaves no result waiting and the input open.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("result or full flag survived reset");

    // A waiting result holds until it is taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_chosen_sample)
                           && $stable(o_contribution_weight))
        else $error("waiting result changed or vanished");

    // A choice with zero target carries zero contribution weight.
    a_zero_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_chosen_target == '0) |-> (o_contribution_weight == '0))
        else $error("nonzero contribution weight for zero target");

endmodule

bind weighted_reservoir_sampler_core wrs_checker u_wrs_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .full                  (full),
    .empty                 (empty),
    .pop                   (pop),
    .o_chosen_sample       (o_chosen_sample),
    .o_chosen_target       (o_chosen_target),
    .o_contribution_weight (o_contribution_weight)
);
